FILE: hdl/lru_table_with_pinned_entries_assert.svh
// ----------------------------------------------------------------------------
// LRU table assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef LRU_TABLE_WITH_PINNED_ENTRIES_ASSERT_SVH
`define LRU_TABLE_WITH_PINNED_ENTRIES_ASSERT_SVH

// Check cons in the same cycle as ante
`define LRUT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante
`define LRUT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/lrut_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU table package
// Sizes, request and status codes, sequencer states and shared types.
// ----------------------------------------------------------------------------
package lrut_pkg;

    localparam int SLOTS    = 16;
    localparam int KEY_BITS = 32;
    localparam int PIN_BITS = 8;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int CAP_W  = 5;
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int CLK_W  = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [CLK_W-1:0]    t_stamp;
    typedef logic [PIN_BITS-1:0] t_pins;
    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [CNT_W-1:0]    t_count;

    localparam t_pins PIN_MAX = {PIN_BITS{1'b1}};

    typedef enum logic [2:0] {
        REQ_INSERT  = 3'd0,
        REQ_REMOVE  = 3'd1,
        REQ_ACQUIRE = 3'd2,
        REQ_RELEASE = 3'd3,
        REQ_QUERY   = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_UNKNOWN   = 2'd1,
        STAT_EXHAUSTED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } t_state;

    // Sequencer controls for the datapath
    typedef struct packed {
        logic  busy;
        logic  accept;
        logic  rd_en;
        t_slot rd_addr;
        logic  decide;
    } t_ctrl;

endpackage

FILE: hdl/lrut_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU table slot store
// Per-slot key, stamp and pin count; one write port, one registered read.
// ----------------------------------------------------------------------------
module lrut_store (
    input  logic            i_clk,
    input  logic            i_rd_en,
    input  lrut_pkg::t_slot  i_rd_addr,
    output lrut_pkg::t_key   o_rd_key,
    output lrut_pkg::t_stamp o_rd_stamp,
    output lrut_pkg::t_pins  o_rd_pins,
    input  lrut_pkg::t_slot  i_wr_addr,
    input  logic            i_wr_key_en,
    input  logic            i_wr_stamp_en,
    input  logic            i_wr_pins_en,
    input  lrut_pkg::t_key   i_wr_key,
    input  lrut_pkg::t_stamp i_wr_stamp,
    input  lrut_pkg::t_pins  i_wr_pins
);
    import lrut_pkg::*;

    t_key   mem_key   [SLOTS];
    t_stamp mem_stamp [SLOTS];
    t_pins  mem_pins  [SLOTS];

    // Write selected fields of one slot
    always_ff @(posedge i_clk) begin
        if (i_wr_key_en) begin
            mem_key[i_wr_addr] <= i_wr_key;
        end
        if (i_wr_stamp_en) begin
            mem_stamp[i_wr_addr] <= i_wr_stamp;
        end
        if (i_wr_pins_en) begin
            mem_pins[i_wr_addr] <= i_wr_pins;
        end
    end

    // Read one slot, data registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_key   <= mem_key[i_rd_addr];
            o_rd_stamp <= mem_stamp[i_rd_addr];
            o_rd_pins  <= mem_pins[i_rd_addr];
        end
    end

endmodule

FILE: hdl/lrut_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU table compare unit
// Key match and stamp age compare, shared by every scan step.
// ----------------------------------------------------------------------------
module lrut_cmp (
    input  lrut_pkg::t_key   i_key_a,
    input  lrut_pkg::t_key   i_key_b,
    input  lrut_pkg::t_stamp i_stamp_a,
    input  lrut_pkg::t_stamp i_stamp_b,
    output logic            o_key_eq,
    output logic            o_stamp_lt
);
    import lrut_pkg::*;

    // Compare the slot under scan against the request and the current victim
    assign o_key_eq   = (i_key_a == i_key_b);
    assign o_stamp_lt = (i_stamp_a < i_stamp_b);

endmodule

FILE: hdl/lrut_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU table sequencer
// Walks the slot store one slot a cycle, then commits the request.
// ----------------------------------------------------------------------------
module lrut_fsm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output lrut_pkg::t_ctrl o_ctrl
);
    import lrut_pkg::*;

    t_state r_state;
    t_state n_state;
    t_slot  r_idx;
    t_slot  n_idx;
    logic   w_last;

    assign w_last = (r_idx == SLOT_W'(SLOTS - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN:  n_state = S_DECIDE;
            S_DECIDE: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Slot counter: clear while idle, advance while scanning
    always_comb begin
        n_idx = r_idx;
        if (r_state == S_IDLE) begin
            n_idx = '0;
        end else if (r_state == S_SCAN && !w_last) begin
            n_idx = r_idx + SLOT_W'(1);
        end
    end

    // Outputs
    always_comb begin
        o_ctrl         = '0;
        o_ctrl.rd_addr = r_idx;
        unique case (r_state)
            S_IDLE: begin
                o_ctrl.accept = i_start;
            end
            S_SCAN: begin
                o_ctrl.busy  = 1'b1;
                o_ctrl.rd_en = 1'b1;
            end
            S_DRAIN: begin
                o_ctrl.busy = 1'b1;
            end
            S_DECIDE: begin
                o_ctrl.busy   = 1'b1;
                o_ctrl.decide = 1'b1;
            end
            default: begin
                o_ctrl.busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

FILE: hdl/lru_table_with_pinned_entries.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU table with pinned entries
// Keyed table with least-recently-used eviction that skips pinned entries.
// ----------------------------------------------------------------------------
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+-------------------------
//  request   | i_req_type, i_entry_key                 | start high, busy low
//  result    | o_status, o_present, o_slot_index,      | o_strobe, one cycle
//            | o_evicted_valid, o_evicted_key,         |
//            | o_occupancy                             |
//  config    | i_cfg_we, i_cfg_wdata (capacity)        | i_cfg_we, no wait
//
//  A request runs from accept to strobe through the scan, drain and commit
//  states: the scan reads one slot a cycle into the shared compare unit,
//  drain and commit keep busy high, and then comes the strobe cycle,
//  in which busy is low and the next request can be taken.
//  Reset is synchronous, active low, and empties the table.
//  The result cannot be held off: it is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module lru_table_with_pinned_entries (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_req_type,
    input  logic [31:0] i_entry_key,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic        o_present,
    output logic [3:0]  o_slot_index,
    output logic        o_evicted_valid,
    output logic [31:0] o_evicted_key,
    output logic [4:0]  o_occupancy
);
    import lrut_pkg::*;

    t_ctrl w_ctrl;

    // Control state
    logic [CAP_W-1:0] r_cap;
    logic [SLOTS-1:0] r_valid;
    logic [SLOTS-1:0] n_valid;
    t_count           r_count;
    t_count           n_count;
    t_stamp           r_use_clock;
    t_stamp           n_use_clock;
    logic             r_cmp_vld;
    t_slot            r_cmp_idx;

    // Latched request
    logic [2:0] r_req;
    t_key       r_key;

    // Scan results
    logic   r_hit;
    t_slot  r_hit_idx;
    t_pins  r_hit_pins;
    logic   r_free_found;
    t_slot  r_free_idx;
    logic   r_vic_found;
    t_slot  r_vic_idx;
    t_stamp r_vic_stamp;
    t_key   r_vic_key;

    // Store read data and compare results
    t_key   w_rd_key;
    t_stamp w_rd_stamp;
    t_pins  w_rd_pins;
    logic   w_key_eq;
    logic   w_stamp_lt;
    logic   w_slot_valid;

    // Commit decisions
    t_status          n_status;
    logic             n_present;
    t_slot            n_slot;
    logic             n_ev;
    logic             w_wr_key_en;
    logic             w_wr_stamp_en;
    logic             w_wr_pins_en;
    t_slot            w_wr_addr;
    t_pins            w_wr_pins;
    t_stamp           w_new_clock;
    logic [CMP_W-1:0] w_eff_cap;
    logic             w_need_ev;
    t_slot            w_tgt;

    // Result registers
    logic            r_strobe;
    logic [1:0]      r_status;
    logic            r_present;
    t_slot           r_slot;
    logic            r_ev;
    t_key            r_ev_key;
    t_count          r_occ;

    lrut_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_ctrl  (w_ctrl)
    );

    lrut_store u_store (
        .i_clk         (i_clk),
        .i_rd_en       (w_ctrl.rd_en),
        .i_rd_addr     (w_ctrl.rd_addr),
        .o_rd_key      (w_rd_key),
        .o_rd_stamp    (w_rd_stamp),
        .o_rd_pins     (w_rd_pins),
        .i_wr_addr     (w_wr_addr),
        .i_wr_key_en   (w_wr_key_en),
        .i_wr_stamp_en (w_wr_stamp_en),
        .i_wr_pins_en  (w_wr_pins_en),
        .i_wr_key      (r_key),
        .i_wr_stamp    (w_new_clock),
        .i_wr_pins     (w_wr_pins)
    );

    lrut_cmp u_cmp (
        .i_key_a    (w_rd_key),
        .i_key_b    (r_key),
        .i_stamp_a  (w_rd_stamp),
        .i_stamp_b  (r_vic_stamp),
        .o_key_eq   (w_key_eq),
        .o_stamp_lt (w_stamp_lt)
    );

    assign busy         = w_ctrl.busy;
    assign w_slot_valid = r_valid[r_cmp_idx];
    assign w_new_clock  = r_use_clock + CLK_W'(1);

    // Clamp the configured capacity to 1..SLOTS
    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = CMP_W'(1);
        end else if (CMP_W'(r_cap) > CMP_W'(SLOTS)) begin
            w_eff_cap = CMP_W'(SLOTS);
        end else begin
            w_eff_cap = CMP_W'(r_cap);
        end
    end

    assign w_need_ev = (CMP_W'(r_count) >= w_eff_cap) || !r_free_found;

    // Lowest free slot once the victim is gone
    assign w_tgt = !w_need_ev ? r_free_idx :
                   (r_free_found && (r_free_idx < r_vic_idx)) ? r_free_idx : r_vic_idx;

    // Decide the request outcome from the scan
    always_comb begin
        n_status      = STAT_OK;
        n_present     = r_hit;
        n_slot        = r_hit ? r_hit_idx : '0;
        n_ev          = 1'b0;
        n_valid       = r_valid;
        n_count       = r_count;
        n_use_clock   = r_use_clock;
        w_wr_key_en   = 1'b0;
        w_wr_stamp_en = 1'b0;
        w_wr_pins_en  = 1'b0;
        w_wr_addr     = r_hit_idx;
        w_wr_pins     = '0;
        unique case (r_req)
            REQ_INSERT: begin
                n_use_clock = w_new_clock;
                if (r_hit) begin
                    w_wr_stamp_en = 1'b1;
                    w_wr_pins_en  = 1'b1;
                end else if (w_need_ev && !r_vic_found) begin
                    n_status  = STAT_EXHAUSTED;
                    n_present = 1'b0;
                    n_slot    = '0;
                end else begin
                    if (w_need_ev) begin
                        n_ev               = 1'b1;
                        n_valid[r_vic_idx] = 1'b0;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                    n_valid[w_tgt] = 1'b1;
                    w_wr_addr      = w_tgt;
                    w_wr_key_en    = 1'b1;
                    w_wr_stamp_en  = 1'b1;
                    w_wr_pins_en   = 1'b1;
                    n_present      = 1'b1;
                    n_slot         = w_tgt;
                end
            end
            REQ_REMOVE: begin
                if (r_hit) begin
                    n_valid[r_hit_idx] = 1'b0;
                    n_count            = r_count - CNT_W'(1);
                    n_present          = 1'b0;
                    n_slot             = '0;
                end else begin
                    n_status = STAT_UNKNOWN;
                end
            end
            REQ_ACQUIRE: begin
                if (r_hit) begin
                    n_use_clock   = w_new_clock;
                    w_wr_stamp_en = 1'b1;
                    w_wr_pins_en  = 1'b1;
                    w_wr_pins     = (r_hit_pins == PIN_MAX) ? r_hit_pins
                                                            : r_hit_pins + PIN_BITS'(1);
                end else begin
                    n_status = STAT_UNKNOWN;
                end
            end
            REQ_RELEASE: begin
                if (r_hit) begin
                    w_wr_pins_en = (r_hit_pins != '0);
                    w_wr_pins    = r_hit_pins - PIN_BITS'(1);
                end else begin
                    n_status = STAT_UNKNOWN;
                end
            end
            default: begin
                // Query and unused codes only report
            end
        endcase
        if (!w_ctrl.decide) begin
            w_wr_key_en   = 1'b0;
            w_wr_stamp_en = 1'b0;
            w_wr_pins_en  = 1'b0;
        end
    end

    // Control registers: capacity, valid bits, count, use clock, compare valid, strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_valid     <= '0;
            r_count     <= '0;
            r_use_clock <= '0;
            r_cmp_vld   <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (w_ctrl.decide) begin
                r_valid     <= n_valid;
                r_count     <= n_count;
                r_use_clock <= n_use_clock;
            end
            r_cmp_vld <= w_ctrl.rd_en;
            r_strobe  <= w_ctrl.decide;
        end
    end

    // Latch the request and track the slot under compare
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= w_ctrl.rd_addr;
        if (w_ctrl.accept) begin
            r_req <= i_req_type;
            r_key <= KEY_BITS'(i_entry_key);
        end
    end

    // Fold one slot per cycle into hit, free and victim trackers
    always_ff @(posedge i_clk) begin
        if (w_ctrl.accept) begin
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_vic_found  <= 1'b0;
        end else if (r_cmp_vld) begin
            if (w_slot_valid && w_key_eq && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_idx  <= r_cmp_idx;
                r_hit_pins <= w_rd_pins;
            end
            if (!w_slot_valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_cmp_idx;
            end
            if (w_slot_valid && (w_rd_pins == '0) && (!r_vic_found || w_stamp_lt)) begin
                r_vic_found <= 1'b1;
                r_vic_idx   <= r_cmp_idx;
                r_vic_stamp <= w_rd_stamp;
                r_vic_key   <= w_rd_key;
            end
        end
    end

    // Hold the result for its strobe cycle
    always_ff @(posedge i_clk) begin
        if (w_ctrl.decide) begin
            r_status  <= n_status;
            r_present <= n_present;
            r_slot    <= n_slot;
            r_ev      <= n_ev;
            r_ev_key  <= n_ev ? r_vic_key : '0;
            r_occ     <= n_count;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_present       = r_present;
    assign o_slot_index    = 4'(r_slot);
    assign o_evicted_valid = r_ev;
    assign o_evicted_key   = 32'(r_ev_key);
    assign o_occupancy     = 5'(r_occ);

endmodule

FILE: hdl/lrut_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU table port checker
// Watches the top-level ports for sequencing and result consistency.
// ----------------------------------------------------------------------------
`include "lru_table_with_pinned_entries_assert.svh"

module lrut_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  i_req_type,
    input logic [31:0] i_entry_key,
    input logic        i_cfg_we,
    input logic [4:0]  i_cfg_wdata,
    input logic        o_strobe,
    input logic [1:0]  o_status,
    input logic        o_present,
    input logic [3:0]  o_slot_index,
    input logic        o_evicted_valid,
    input logic [31:0] o_evicted_key,
    input logic [4:0]  o_occupancy
);
    import lrut_pkg::*;

    // A taken request keeps the block busy
    `LRUT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy low after accept")

    // The result shows only once the block is free again
    `LRUT_ASSERT_NOW(a_strobe_idle, o_strobe, !busy, "result strobe while busy")

    // A failed request never evicts
    `LRUT_ASSERT_NOW(a_fail_no_evict, o_strobe && (o_status != STAT_OK), !o_evicted_valid,
        "eviction reported on failed request")

    // An absent key reports slot zero
    `LRUT_ASSERT_NOW(a_absent_slot, o_strobe && !o_present, o_slot_index == 4'd0,
        "nonzero slot for absent key")

endmodule

bind lru_table_with_pinned_entries lrut_checker u_lrut_checker (.*);
